/* rtl/core/assert_macros.svh */
// Shared assertion forms for the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, reset disables the check.
`define ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, reset disables the check.
`define ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* rtl/core/y86ie_pkg.sv */
`default_nettype none
package y86ie_pkg;

  localparam int MEM_BYTES_DEF = 4096;
  localparam int PC_W          = 13;
  // wide enough for any address compare against the largest memory
  localparam int CMP_W         = 18;

  // machine status codes
  localparam logic [1:0] ST_AOK = 2'd0;
  localparam logic [1:0] ST_HLT = 2'd1;
  localparam logic [1:0] ST_ADR = 2'd2;
  localparam logic [1:0] ST_INS = 2'd3;

  // instruction codes
  localparam logic [3:0] IC_HALT  = 4'h0;
  localparam logic [3:0] IC_NOP   = 4'h1;
  localparam logic [3:0] IC_RRMOV = 4'h2;
  localparam logic [3:0] IC_IRMOV = 4'h3;
  localparam logic [3:0] IC_RMMOV = 4'h4;
  localparam logic [3:0] IC_MRMOV = 4'h5;
  localparam logic [3:0] IC_OPQ   = 4'h6;
  localparam logic [3:0] IC_JXX   = 4'h7;
  localparam logic [3:0] IC_CALL  = 4'h8;
  localparam logic [3:0] IC_RET   = 4'h9;
  localparam logic [3:0] IC_PUSH  = 4'hA;
  localparam logic [3:0] IC_POP   = 4'hB;

  localparam logic [3:0] REG_NONE = 4'hF;
  localparam logic [3:0] REG_RSP  = 4'h4;

  typedef enum logic [1:0] {ALU_ADD, ALU_SUB, ALU_AND, ALU_XOR} alu_op_t;

  typedef struct packed {
    logic zf;
    logic sf;
    logic of;
  } alu_flags_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_F0, S_FB, S_CHECK, S_RA, S_RB,
    S_ALU, S_MWR, S_MRD, S_INC, S_WB, S_DONE
  } seq_state_t;

  // Encoded length of an instruction from its opcode.
  function automatic logic [3:0] instr_len(input logic [3:0] ic);
    case (ic)
      IC_RRMOV, IC_OPQ, IC_PUSH, IC_POP: instr_len = 4'd2;
      IC_JXX, IC_CALL:                   instr_len = 4'd9;
      IC_IRMOV, IC_RMMOV, IC_MRMOV:      instr_len = 4'd10;
      default:                           instr_len = 4'd1;
    endcase
  endfunction

  // Branch and move condition from the function code.
  function automatic logic cond_holds(input logic [3:0] fn, input logic zf,
                                      input logic sf, input logic of);
    logic lt;
    lt = sf ^ of;
    case (fn)
      4'd0:    cond_holds = 1'b1;
      4'd1:    cond_holds = lt | zf;
      4'd2:    cond_holds = lt;
      4'd3:    cond_holds = zf;
      4'd4:    cond_holds = !zf;
      4'd5:    cond_holds = !lt;
      4'd6:    cond_holds = !lt && !zf;
      default: cond_holds = 1'b0;
    endcase
  endfunction

endpackage
`default_nettype wire

/* rtl/core/y86ie_ram.sv */
`default_nettype none
module y86ie_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write one entry, register the read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/core/y86ie_alu.sv */
`default_nettype none
module y86ie_alu import y86ie_pkg::*; (
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  input  wire alu_op_t     op,
  output logic      [63:0] r,
  output alu_flags_t       flags
);

  // compute b op a
  always_comb begin
    case (op)
      ALU_ADD: r = b + a;
      ALU_SUB: r = b - a;
      ALU_AND: r = b & a;
      ALU_XOR: r = b ^ a;
      default: r = b + a;
    endcase
  end

  // derive condition flags from the result
  always_comb begin
    flags.zf = (r == 64'd0);
    flags.sf = r[63];
    case (op)
      ALU_ADD: flags.of = (a[63] ^ r[63]) & (b[63] ^ r[63]);
      ALU_SUB: flags.of = (b[63] ^ a[63]) & (b[63] ^ r[63]);
      default: flags.of = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/core/y86_instruction_executor_top.sv */
// Sequential Y86-64 core with a byte memory and fifteen 64-bit registers.
// Command channel (cmd_valid / cmd_stall): action 0 stores load_byte at
// load_address, action 1 executes one instruction at the program counter.
// Response channel (rsp_valid / rsp_stall): one item per command with the
// machine status, the PC, the flags and any register write.
// A load item goes straight to the done state after accept. An execute item
// fetches its bytes, checks them, reads two registers and uses the adder,
// then writes or reads eight data bytes where it needs them (ret and popq
// also step the stack pointer) and writes back; it stops early on halt or a
// fault. Every instruction and data byte goes through the single byte-wide
// memory, one byte per cycle, and the register file and the 64-bit adder are
// each used over several steps. The next item can be accepted in the same
// cycle the response appears. cmd_stall is high while an item is in flight.
// After reset a clearing pass zeroes memory and registers, one byte a cycle;
// cmd_stall stays high meanwhile.
// A stalled response holds; the core finishes the next item into its
// internal state and waits until the response register is free.
// Once a halt or fault is reported, execute items change nothing.
`default_nettype none
module y86_instruction_executor_top import y86ie_pkg::*; #(
  parameter int MEM_BYTES = MEM_BYTES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cmd_valid,
  output logic                    cmd_stall,
  input  wire logic               action,
  input  wire logic [11:0]        load_address,
  input  wire logic [7:0]         load_byte,
  output logic                    rsp_valid,
  input  wire logic               rsp_stall,
  output logic [1:0]              run_status,
  output logic [PC_W-1:0]         next_pc,
  output logic                    flag_zero,
  output logic                    flag_sign,
  output logic                    flag_overflow,
  output logic                    reg_written,
  output logic [3:0]              reg_index,
  output logic signed [63:0]      reg_value
);

  localparam int AW = $clog2(MEM_BYTES);
  localparam logic [CMP_W-1:0] MEM_LIM   = CMP_W'(MEM_BYTES);
  localparam logic [63:0]      MEM_LIM64 = 64'(MEM_BYTES);
  localparam logic [63:0]      IN8_LIM   = 64'(MEM_BYTES - 7);
  localparam logic [AW-1:0]    CLR_LAST  = AW'(MEM_BYTES - 1);

  seq_state_t state, state_next;

  // architectural state
  logic [AW-1:0]   clr;
  logic [PC_W-1:0] pc, npc;
  logic            zf, sf, of;
  logic [1:0]      mstat;

  // instruction and work registers
  logic [3:0]  icode, ifun, ra, rb, len, bcnt, bgot, bn;
  logic [63:0] imm, vala, valb, maddr, wval;
  logic        res_w;
  logic [3:0]  res_idx;
  logic [63:0] res_val;

  // memory and register file ports
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata;
  logic          rf_we;
  logic [3:0]    rf_waddr, rf_raddr;
  logic [63:0]   rf_wdata, rf_rdata;

  // shared adder
  logic [63:0] alu_a, alu_b, alu_r;
  alu_op_t     alu_op;
  alu_flags_t  alu_fl;

  logic             cmd_acc, rsp_free;
  logic [CMP_W-1:0] pc18, ld18, pcp1;
  logic [AW-1:0]    pc_a1, maddr_a;
  logic [3:0]       len_f0;
  logic             pc_in, fetch_fits, ld_in, cond_ok, imm_ok, addr_ok;
  logic             valid_ok, is_stack, fb_last, mrd_cap;
  logic [63:0]      ret_addr, rd_word;

  y86ie_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  y86ie_ram #(.WIDTH(64), .DEPTH(16)) u_rf (
    .clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
    .raddr(rf_raddr), .rdata(rf_rdata)
  );

  y86ie_alu u_alu (.a(alu_a), .b(alu_b), .op(alu_op), .r(alu_r), .flags(alu_fl));

  assign cmd_stall = (state != S_IDLE);
  assign cmd_acc   = cmd_valid && !cmd_stall;
  assign rsp_free  = !(rsp_valid && rsp_stall);

  // address checks and decode helpers
  assign pc18       = CMP_W'(pc);
  assign ld18       = CMP_W'(load_address);
  assign pcp1       = pc18 + CMP_W'(1);
  assign pc_a1      = pcp1[AW-1:0];
  assign maddr_a    = maddr[AW-1:0];
  assign len_f0     = instr_len(mem_rdata[7:4]);
  assign pc_in      = pc18 < MEM_LIM;
  assign ld_in      = ld18 < MEM_LIM;
  assign fetch_fits = (pc18 + CMP_W'(len_f0)) <= MEM_LIM;
  assign cond_ok    = cond_holds(ifun, zf, sf, of);
  assign imm_ok     = imm < MEM_LIM64;
  assign addr_ok    = alu_r < IN8_LIM;
  assign is_stack   = icode inside {IC_CALL, IC_RET, IC_PUSH, IC_POP};
  assign fb_last    = (bgot + 4'd1) == bn;
  assign mrd_cap    = bgot < bcnt;
  assign ret_addr   = 64'(pc) + 64'(len);
  assign rd_word    = {mem_rdata, wval[63:8]};

  // check the fetched fields
  always_comb begin
    case (icode)
      IC_HALT, IC_NOP, IC_CALL, IC_RET: valid_ok = (ifun == 4'd0);
      IC_RRMOV: valid_ok = (ifun <= 4'd6) && ra != REG_NONE && rb != REG_NONE;
      IC_IRMOV: valid_ok = (ifun == 4'd0) && ra == REG_NONE && rb != REG_NONE;
      IC_RMMOV, IC_MRMOV:
        valid_ok = (ifun == 4'd0) && ra != REG_NONE && rb != REG_NONE;
      IC_OPQ:   valid_ok = (ifun <= 4'd3) && ra != REG_NONE && rb != REG_NONE;
      IC_JXX:   valid_ok = (ifun <= 4'd6);
      IC_PUSH, IC_POP:
        valid_ok = (ifun == 4'd0) && ra != REG_NONE && rb == REG_NONE;
      default:  valid_ok = 1'b0;
    endcase
  end

  // select adder operands
  always_comb begin
    alu_a  = vala;
    alu_b  = valb;
    alu_op = ALU_ADD;
    if (state == S_ALU) begin
      case (icode)
        IC_OPQ:             alu_op = alu_op_t'(ifun[1:0]);
        IC_RMMOV, IC_MRMOV: alu_a  = imm;
        IC_CALL, IC_PUSH: begin
          alu_a  = 64'd8;
          alu_op = ALU_SUB;
        end
        default:            alu_a  = 64'd0;
      endcase
    end else if (state == S_INC) begin
      alu_a = 64'd8;
      alu_b = maddr;
    end
  end

  // sequence the steps
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr == CLR_LAST) state_next = S_IDLE;
      S_IDLE: begin
        if (cmd_acc) begin
          state_next = (action && mstat == ST_AOK && pc_in) ? S_F0 : S_DONE;
        end
      end
      S_F0: begin
        if (!fetch_fits)         state_next = S_DONE;
        else if (len_f0 == 4'd1) state_next = S_CHECK;
        else                     state_next = S_FB;
      end
      S_FB:    if (fb_last) state_next = S_CHECK;
      S_CHECK: state_next = (!valid_ok || icode == IC_HALT) ? S_DONE : S_RA;
      S_RA:    state_next = S_RB;
      S_RB:    state_next = S_ALU;
      S_ALU: begin
        case (icode)
          IC_CALL: state_next = (imm_ok && addr_ok) ? S_MWR : S_DONE;
          IC_PUSH, IC_RMMOV: state_next = addr_ok ? S_MWR : S_DONE;
          IC_MRMOV, IC_RET, IC_POP: state_next = addr_ok ? S_MRD : S_DONE;
          IC_JXX: state_next = (cond_ok && !imm_ok) ? S_DONE : S_WB;
          default: state_next = S_WB;
        endcase
      end
      S_MWR: if (bcnt == 4'd7) state_next = S_WB;
      S_MRD: begin
        if (mrd_cap && bgot == 4'd7) begin
          state_next = (icode == IC_MRMOV) ? S_WB : S_INC;
        end
      end
      S_INC: begin
        state_next = (icode == IC_RET && !(wval < MEM_LIM64)) ? S_DONE : S_WB;
      end
      S_WB:   state_next = S_DONE;
      S_DONE: if (rsp_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // drive memory and register file ports
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = maddr_a + AW'(bcnt);
    mem_wdata = wval[7:0];
    mem_raddr = pc18[AW-1:0];
    rf_we     = 1'b0;
    rf_waddr  = res_idx;
    rf_wdata  = res_val;
    rf_raddr  = ra;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr;
        mem_wdata = 8'd0;
        rf_we     = (clr < AW'(16));
        rf_waddr  = clr[3:0];
        rf_wdata  = 64'd0;
      end
      S_IDLE: begin
        mem_we    = cmd_acc && !action && ld_in;
        mem_waddr = ld18[AW-1:0];
        mem_wdata = load_byte;
      end
      S_F0:  mem_raddr = pc_a1;
      S_FB:  mem_raddr = pc_a1 + AW'(bcnt);
      S_RA:  rf_raddr  = is_stack ? REG_RSP : rb;
      S_MWR: mem_we    = 1'b1;
      S_MRD: mem_raddr = maddr_a + AW'(bcnt);
      S_INC: begin
        rf_we    = (icode == IC_POP);
        rf_waddr = REG_RSP;
        rf_wdata = alu_r;
      end
      S_WB:  rf_we = res_w;
      default: ;
    endcase
  end

  // advance the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // hold architectural control state
  always_ff @(posedge clk) begin
    if (rst) begin
      clr   <= '0;
      pc    <= '0;
      zf    <= 1'b0;
      sf    <= 1'b0;
      of    <= 1'b0;
      mstat <= ST_AOK;
    end else begin
      case (state)
        S_CLEAR: clr <= clr + AW'(1);
        S_IDLE: begin
          if (cmd_acc && action && mstat == ST_AOK && !pc_in) mstat <= ST_ADR;
        end
        S_F0:    if (!fetch_fits) mstat <= ST_ADR;
        S_CHECK: begin
          if (!valid_ok)              mstat <= ST_INS;
          else if (icode == IC_HALT)  mstat <= ST_HLT;
        end
        S_ALU: begin
          case (icode)
            IC_OPQ: begin
              zf <= alu_fl.zf;
              sf <= alu_fl.sf;
              of <= alu_fl.of;
            end
            IC_CALL: if (!imm_ok || !addr_ok) mstat <= ST_ADR;
            IC_JXX:  if (cond_ok && !imm_ok) mstat <= ST_ADR;
            IC_PUSH, IC_RMMOV, IC_MRMOV, IC_RET, IC_POP:
              if (!addr_ok) mstat <= ST_ADR;
            default: ;
          endcase
        end
        S_INC:   if (icode == IC_RET && !(wval < MEM_LIM64)) mstat <= ST_ADR;
        S_WB:    pc <= npc;
        default: ;
      endcase
    end
  end

  // hold instruction fields, operands and the pending register write
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        res_w   <= 1'b0;
        res_idx <= 4'd0;
        res_val <= 64'd0;
      end
      S_F0: begin
        icode <= mem_rdata[7:4];
        ifun  <= mem_rdata[3:0];
        len   <= len_f0;
        ra    <= REG_NONE;
        rb    <= REG_NONE;
        imm   <= 64'd0;
        bcnt  <= 4'd1;
        bgot  <= 4'd0;
        bn    <= len_f0 - 4'd1;
      end
      S_FB: begin
        if (bgot == 4'd0 && (len == 4'd2 || len == 4'd10)) begin
          ra <= mem_rdata[7:4];
          rb <= mem_rdata[3:0];
        end else begin
          imm <= {mem_rdata, imm[63:8]};
        end
        bgot <= bgot + 4'd1;
        if (bcnt < bn) bcnt <= bcnt + 4'd1;
      end
      S_CHECK: npc <= PC_W'(pc + PC_W'(len));
      S_RA:    vala <= rf_rdata;
      S_RB:    valb <= rf_rdata;
      S_ALU: begin
        maddr <= alu_r;
        bcnt  <= 4'd0;
        bgot  <= 4'd0;
        case (icode)
          IC_RRMOV: begin
            if (cond_ok) begin
              res_w   <= 1'b1;
              res_idx <= rb;
              res_val <= vala;
            end
          end
          IC_IRMOV: begin
            res_w   <= 1'b1;
            res_idx <= rb;
            res_val <= imm;
          end
          IC_OPQ: begin
            res_w   <= 1'b1;
            res_idx <= rb;
            res_val <= alu_r;
          end
          IC_JXX: if (cond_ok) npc <= imm[PC_W-1:0];
          IC_CALL: begin
            wval <= ret_addr;
            npc  <= imm[PC_W-1:0];
            // report rsp only when the call goes ahead
            if (imm_ok && addr_ok) begin
              res_w   <= 1'b1;
              res_idx <= REG_RSP;
              res_val <= alu_r;
            end
          end
          IC_PUSH: begin
            wval <= vala;
            if (addr_ok) begin
              res_w   <= 1'b1;
              res_idx <= REG_RSP;
              res_val <= alu_r;
            end
          end
          IC_RMMOV: wval <= vala;
          default: ;
        endcase
      end
      S_MWR: begin
        wval <= {8'd0, wval[63:8]};
        bcnt <= bcnt + 4'd1;
      end
      S_MRD: begin
        if (bcnt < 4'd8) bcnt <= bcnt + 4'd1;
        if (mrd_cap) begin
          wval <= rd_word;
          bgot <= bgot + 4'd1;
          if (bgot == 4'd7 && icode == IC_MRMOV) begin
            res_w   <= 1'b1;
            res_idx <= ra;
            res_val <= rd_word;
          end
        end
      end
      S_INC: begin
        if (icode == IC_RET) begin
          npc <= wval[PC_W-1:0];
          if (wval < MEM_LIM64) begin
            res_w   <= 1'b1;
            res_idx <= REG_RSP;
            res_val <= alu_r;
          end
        end else begin
          res_w   <= 1'b1;
          res_idx <= ra;
          res_val <= wval;
        end
      end
      default: ;
    endcase
  end

  // present the response item, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_DONE && rsp_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && rsp_free) begin
      run_status    <= mstat;
      next_pc       <= pc;
      flag_zero     <= zf;
      flag_sign     <= sf;
      flag_overflow <= of;
      reg_written   <= res_w;
      reg_index     <= res_idx;
      reg_value     <= res_val;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/y86ie_checker.sv */
`default_nettype none
`include "assert_macros.svh"
module y86ie_checker import y86ie_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              cmd_valid,
  input wire logic              cmd_stall,
  input wire logic              rsp_valid,
  input wire logic              rsp_stall,
  input wire logic [1:0]        run_status,
  input wire logic [PC_W-1:0]   next_pc,
  input wire logic              reg_written,
  input wire logic [3:0]        reg_index,
  input wire logic [63:0]       reg_value
);

  // an accepted command item blocks the next one
  `ASSERT_NXT(a_cmd_busy, clk, rst, cmd_valid && !cmd_stall, cmd_stall)

  // a stalled response item holds
  `ASSERT_NXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid && $stable(next_pc) && $stable(reg_value))

  // no register write reports zero index and value
  `ASSERT_IMP(a_nowrite_zero, clk, rst, rsp_valid && !reg_written, reg_index == 4'd0 && reg_value == 64'd0)

  // a write never targets the missing register
  `ASSERT_IMP(a_idx_range, clk, rst, rsp_valid && reg_written, reg_index != REG_NONE)

  // a stopped machine writes nothing
  `ASSERT_IMP(a_stop_nowrite, clk, rst, rsp_valid && run_status != ST_AOK, !reg_written)

endmodule

bind y86_instruction_executor_top y86ie_checker u_checker (.*);
`default_nettype wire

/* tb/sv/tb_y86_instruction_executor_top.sv */
`timescale 1ns / 1ps
module tb_y86_instruction_executor_top;
  import y86ie_pkg::*;

  localparam int MEMSZ = 4096;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int ITEM_TARGET = 1950;
  localparam int CODE_TOP = 3870;

  typedef struct packed {
    logic [1:0]  status;
    logic [12:0] pc;
    logic        zf;
    logic        sf;
    logic        of;
    logic        wr;
    logic [3:0]  idx;
    logic [63:0] val;
  } outcome_t;

  typedef struct packed {
    logic        is_load;
    logic        typed;
    logic [11:0] addr;
    logic [3:0]  len;
    logic [79:0] enc;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  logic action = 1'b0;
  logic [11:0] load_address = '0;
  logic [7:0] load_byte = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  logic [1:0] run_status;
  logic [PC_W-1:0] next_pc;
  logic flag_zero, flag_sign, flag_overflow, reg_written;
  logic [3:0] reg_index;
  logic signed [63:0] reg_value;

  // shadow machine state
  logic [63:0] core_regs [15];
  logic [7:0]  core_mem [MEMSZ];
  logic [12:0] core_pc;
  logic        core_zf, core_sf, core_of;
  logic [1:0]  core_status;

  outcome_t pending_q[$];
  logic [7:0] ibuf [10];
  int err_count = 0;
  int sent = 0;
  int cycles = 0;
  int rsp_seen = 0;
  int hold_left = 0;
  bit held = 1'b0;

  y86_instruction_executor_top i_dut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
    .action(action), .load_address(load_address), .load_byte(load_byte),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .run_status(run_status), .next_pc(next_pc),
    .flag_zero(flag_zero), .flag_sign(flag_sign), .flag_overflow(flag_overflow),
    .reg_written(reg_written), .reg_index(reg_index), .reg_value(reg_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit fits(logic [63:0] a, int n);
    return a < MEMSZ && 64'(n) <= 64'(MEMSZ) - a;
  endfunction

  function automatic logic [63:0] mem_word(logic [63:0] a);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < 8; i++) v |= 64'(core_mem[12'(a + i)]) << (8 * i);
    return v;
  endfunction

  function automatic void put_word(logic [63:0] a, logic [63:0] v);
    for (int i = 0; i < 8; i++) core_mem[12'(a + i)] = v[8*i +: 8];
  endfunction

  function automatic bit cond_true(logic [3:0] fn);
    logic lt;
    lt = core_sf ^ core_of;
    case (fn)
      4'd0: return 1'b1;
      4'd1: return lt | core_zf;
      4'd2: return lt;
      4'd3: return core_zf;
      4'd4: return !core_zf;
      4'd5: return !lt;
      4'd6: return !lt && !core_zf;
      default: return 1'b0;
    endcase
  endfunction

  // run one instruction on the shadow state
  function automatic logic [1:0] run_instr(output logic w, output logic [3:0] idx,
                                           output logic [63:0] val);
    logic [63:0] pc, npc, imm, addr, a, b, r, t;
    logic [3:0] ic, fn, ra, rb;
    int len;
    bit ok;
    w = 1'b0; idx = '0; val = '0;
    pc = 64'(core_pc); imm = '0; ra = REG_NONE; rb = REG_NONE;
    if (!fits(pc, 1)) return ST_ADR;
    ic = core_mem[pc[11:0]][7:4];
    fn = core_mem[pc[11:0]][3:0];
    case (ic)
      IC_RRMOV, IC_OPQ, IC_PUSH, IC_POP: len = 2;
      IC_JXX, IC_CALL: len = 9;
      IC_IRMOV, IC_RMMOV, IC_MRMOV: len = 10;
      default: len = 1;
    endcase
    if (!fits(pc, len)) return ST_ADR;
    if (len == 2 || len == 10) begin
      ra = core_mem[pc[11:0] + 1][7:4];
      rb = core_mem[pc[11:0] + 1][3:0];
    end
    if (len == 9) imm = mem_word(pc + 1);
    if (len == 10) imm = mem_word(pc + 2);
    npc = pc + len;
    case (ic)
      IC_HALT, IC_NOP, IC_CALL, IC_RET: ok = fn == 0;
      IC_RRMOV: ok = fn <= 6 && ra != REG_NONE && rb != REG_NONE;
      IC_IRMOV: ok = fn == 0 && ra == REG_NONE && rb != REG_NONE;
      IC_RMMOV, IC_MRMOV: ok = fn == 0 && ra != REG_NONE && rb != REG_NONE;
      IC_OPQ: ok = fn <= 3 && ra != REG_NONE && rb != REG_NONE;
      IC_JXX: ok = fn <= 6;
      IC_PUSH, IC_POP: ok = fn == 0 && ra != REG_NONE && rb == REG_NONE;
      default: ok = 1'b0;
    endcase
    if (!ok) return ST_INS;
    if (ra == REG_NONE) ra = 4'd0;
    if (rb == REG_NONE) rb = 4'd0;
    case (ic)
      IC_HALT: return ST_HLT;
      IC_RRMOV: if (cond_true(fn)) begin
        w = 1'b1; idx = rb; val = core_regs[ra];
      end
      IC_IRMOV: begin
        w = 1'b1; idx = rb; val = imm;
      end
      IC_RMMOV: begin
        addr = core_regs[rb] + imm;
        if (!fits(addr, 8)) return ST_ADR;
        put_word(addr, core_regs[ra]);
      end
      IC_MRMOV: begin
        addr = core_regs[rb] + imm;
        if (!fits(addr, 8)) return ST_ADR;
        w = 1'b1; idx = ra; val = mem_word(addr);
      end
      IC_OPQ: begin
        a = core_regs[ra];
        b = core_regs[rb];
        if (fn == 4'(ALU_ADD)) begin
          r = b + a;
          core_of = (a[63] ^ r[63]) & (b[63] ^ r[63]);
        end else if (fn == 4'(ALU_SUB)) begin
          r = b - a;
          core_of = (b[63] ^ a[63]) & (b[63] ^ r[63]);
        end else begin
          r = (fn == 4'(ALU_AND)) ? (b & a) : (b ^ a);
          core_of = 1'b0;
        end
        core_zf = r == 0;
        core_sf = r[63];
        w = 1'b1; idx = rb; val = r;
      end
      IC_JXX: if (cond_true(fn)) begin
        if (imm >= MEMSZ) return ST_ADR;
        npc = imm;
      end
      IC_CALL: begin
        if (imm >= MEMSZ) return ST_ADR;
        addr = core_regs[REG_RSP] - 8;
        if (!fits(addr, 8)) return ST_ADR;
        put_word(addr, npc);
        w = 1'b1; idx = REG_RSP; val = addr;
        npc = imm;
      end
      IC_RET: begin
        addr = core_regs[REG_RSP];
        if (!fits(addr, 8)) return ST_ADR;
        t = mem_word(addr);
        if (t >= MEMSZ) return ST_ADR;
        w = 1'b1; idx = REG_RSP; val = addr + 8;
        npc = t;
      end
      IC_PUSH: begin
        addr = core_regs[REG_RSP] - 8;
        if (!fits(addr, 8)) return ST_ADR;
        put_word(addr, core_regs[ra]);
        w = 1'b1; idx = REG_RSP; val = addr;
      end
      IC_POP: begin
        addr = core_regs[REG_RSP];
        if (!fits(addr, 8)) return ST_ADR;
        core_regs[REG_RSP] = addr + 8;
        w = 1'b1; idx = ra; val = mem_word(addr);
      end
      default: ;
    endcase
    if (w) core_regs[idx] = val;
    core_pc = npc[12:0];
    return ST_AOK;
  endfunction

  function automatic outcome_t predict_item(logic act, logic [11:0] a, logic [7:0] b);
    outcome_t o;
    logic w;
    logic [3:0] idx;
    logic [63:0] val;
    o = '0;
    w = 1'b0; idx = '0; val = '0;
    if (!act) core_mem[a] = b;
    else if (core_status == ST_AOK) begin
      core_status = run_instr(w, idx, val);
      if (core_status != ST_AOK) begin
        w = 1'b0; idx = '0; val = '0;
      end
    end
    o.status = core_status; o.pc = core_pc;
    o.zf = core_zf; o.sf = core_sf; o.of = core_of;
    o.wr = w; o.idx = idx; o.val = val;
    return o;
  endfunction

  // offer one item, with random gaps outside the quiet window
  task automatic send_item(logic act, logic [11:0] a, logic [7:0] b, bit typed);
    outcome_t o;
    o = predict_item(act, a, b);
    if (typed) o = '0;
    pending_q.push_back(o);
    if (sent < 900 || sent > 1200)
      while ($urandom_range(99) < 38) begin
        cmd_valid <= 1'b0;
        @(posedge clk);
      end
    cmd_valid <= 1'b1;
    action <= act;
    load_address <= a;
    load_byte <= b;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    sent++;
  endtask

  // place the instruction in ibuf at the PC, then run it
  task automatic emit(int len);
    logic [11:0] base;
    base = core_pc[11:0];
    for (int k = 0; k < len; k++) send_item(1'b0, base + 12'(k), ibuf[k], 1'b0);
    send_item(1'b1, 12'($urandom), 8'($urandom), 1'b0);
  endtask

  function automatic void set_imm(int at, logic [63:0] v);
    for (int i = 0; i < 8; i++) ibuf[at + i] = v[8*i +: 8];
  endfunction

  task automatic load_imm(logic [3:0] rb, logic [63:0] v);
    ibuf[0] = {IC_IRMOV, 4'd0};
    ibuf[1] = {REG_NONE, rb};
    set_imm(2, v);
    emit(10);
  endtask

  // keep the stack inside the data area above the code
  task automatic fix_stack();
    logic [63:0] sp;
    sp = core_regs[REG_RSP];
    if (sp < 3928 || sp > 4088) load_imm(REG_RSP, 64'($urandom_range(3928, 4088)));
  endtask

  function automatic logic [3:0] any_reg();
    return 4'($urandom_range(0, 14));
  endfunction

  function automatic logic [63:0] any_value();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      2: return {1'b1, 63'd0};
      3: return {1'b0, {63{1'b1}}};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic random_instr();
    logic [3:0] ra, rb, fn;
    logic [63:0] target;
    ra = any_reg();
    rb = any_reg();
    if (core_pc > CODE_TOP) begin
      ibuf[0] = {IC_JXX, 4'd0};
      set_imm(1, 64'($urandom_range(0, CODE_TOP)));
      emit(9);
      return;
    end
    case ($urandom_range(0, 12))
      0: send_item(1'b0, 12'($urandom), 8'($urandom), 1'b0);
      1: begin
        ibuf[0] = {IC_NOP, 4'd0};
        emit(1);
      end
      2: begin
        ibuf[0] = {IC_RRMOV, 4'($urandom_range(0, 6))};
        ibuf[1] = {ra, rb};
        emit(2);
      end
      3, 4: load_imm(rb, any_value());
      5: begin
        target = 64'($urandom_range(3904, 4088));
        ibuf[0] = {IC_RMMOV, 4'd0};
        ibuf[1] = {ra, rb};
        set_imm(2, target - core_regs[rb]);
        emit(10);
      end
      6: begin
        target = 64'($urandom_range(3904, 4088));
        ibuf[0] = {IC_MRMOV, 4'd0};
        ibuf[1] = {ra, rb};
        set_imm(2, target - core_regs[rb]);
        emit(10);
      end
      7, 8: begin
        ibuf[0] = {IC_OPQ, 4'($urandom_range(0, 3))};
        ibuf[1] = {ra, rb};
        emit(2);
      end
      9: begin
        ibuf[0] = {IC_JXX, 4'($urandom_range(0, 6))};
        set_imm(1, 64'($urandom_range(0, CODE_TOP)));
        emit(9);
      end
      10: begin
        fix_stack();
        ibuf[0] = {IC_CALL, 4'd0};
        set_imm(1, 64'($urandom_range(0, CODE_TOP)));
        emit(9);
      end
      11: begin
        fix_stack();
        target = 64'($urandom_range(0, CODE_TOP));
        for (int i = 0; i < 8; i++)
          send_item(1'b0, 12'(core_regs[REG_RSP] + i), target[8*i +: 8], 1'b0);
        ibuf[0] = {IC_RET, 4'd0};
        emit(1);
      end
      default: begin
        fix_stack();
        fn = $urandom_range(0, 1) ? IC_PUSH : IC_POP;
        ibuf[0] = {fn, 4'd0};
        ibuf[1] = {ra, REG_NONE};
        emit(2);
      end
    endcase
  endtask

  dir_row_t dir_tab [23];

  initial begin
    dir_tab = '{
      '{1'b1, 1'b1, 12'd4095, 4'd1, 80'hFF00_0000_0000_0000_0000},
      '{1'b1, 1'b1, 12'd0,    4'd1, 80'h0000_0000_0000_0000_0000},
      '{1'b0, 1'b0, 12'd0, 4'd10, 80'h30F0_FFFF_FFFF_FFFF_FF7F},
      '{1'b0, 1'b0, 12'd0, 4'd10, 80'h30F3_0100_0000_0000_0000},
      '{1'b0, 1'b0, 12'd0, 4'd2,  80'h6003_0000_0000_0000_0000},
      '{1'b0, 1'b0, 12'd0, 4'd2,  80'h2203_0000_0000_0000_0000},
      '{1'b0, 1'b0, 12'd0, 4'd2,  80'h6103_0000_0000_0000_0000},
      '{1'b0, 1'b0, 12'd0, 4'd2,  80'h6203_0000_0000_0000_0000},
      '{1'b0, 1'b0, 12'd0, 4'd2,  80'h6333_0000_0000_0000_0000},
      '{1'b0, 1'b0, 12'd0, 4'd2,  80'h2303_0000_0000_0000_0000},
      '{1'b0, 1'b0, 12'd0, 4'd10, 80'h30F4_A00F_0000_0000_0000},
      '{1'b0, 1'b0, 12'd0, 4'd2,  80'hA04F_0000_0000_0000_0000},
      '{1'b0, 1'b0, 12'd0, 4'd2,  80'hB04F_0000_0000_0000_0000},
      '{1'b0, 1'b0, 12'd0, 4'd10, 80'h4004_F8FF_FFFF_FFFF_FFFF},
      '{1'b0, 1'b0, 12'd0, 4'd10, 80'h5014_F8FF_FFFF_FFFF_FFFF},
      '{1'b0, 1'b0, 12'd0, 4'd2,  80'hA0EF_0000_0000_0000_0000},
      '{1'b0, 1'b0, 12'd0, 4'd2,  80'hB01F_0000_0000_0000_0000},
      '{1'b0, 1'b0, 12'd0, 4'd9,  80'h8000_0100_0000_0000_0000},
      '{1'b0, 1'b0, 12'd0, 4'd1,  80'h9000_0000_0000_0000_0000},
      '{1'b0, 1'b0, 12'd0, 4'd9,  80'h7000_0200_0000_0000_0000},
      '{1'b0, 1'b0, 12'd0, 4'd9,  80'h7400_0300_0000_0000_0000},
      '{1'b0, 1'b0, 12'd0, 4'd1,  80'h1000_0000_0000_0000_0000},
      '{1'b0, 1'b0, 12'd0, 4'd2,  80'h2631_0000_0000_0000_0000}
    };
    for (int i = 0; i < 15; i++) core_regs[i] = '0;
    for (int i = 0; i < MEMSZ; i++) core_mem[i] = '0;
    core_pc = '0;
    core_zf = 1'b0; core_sf = 1'b0; core_of = 1'b0;
    core_status = ST_AOK;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed program walk
    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_load) begin
        send_item(1'b0, dir_tab[i].addr, dir_tab[i].enc[79:72], dir_tab[i].typed);
      end else begin
        for (int k = 0; k < 10; k++) ibuf[k] = dir_tab[i].enc[79 - 8 * k -: 8];
        emit(int'(dir_tab[i].len));
      end
    end

    // random well-formed program stream
    while (sent < ITEM_TARGET) random_instr();

    // stop the machine one way, then show that it stays stopped
    case ($urandom_range(0, 3))
      0: ibuf[0] = {IC_HALT, 4'd0};
      1: ibuf[0] = {4'hC, 4'd0};
      2: begin
        ibuf[0] = {IC_RRMOV, 4'd7};
        ibuf[1] = 8'h01;
      end
      default: begin
        ibuf[0] = {IC_JXX, 4'd0};
        set_imm(1, 64'h1F00);
      end
    endcase
    emit(9);
    send_item(1'b1, '0, '0, 1'b0);
    send_item(1'b0, 12'd4095, 8'h5A, 1'b0);
    send_item(1'b1, '0, '0, 1'b0);
    cmd_valid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (err_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  // response side: random stalls, one long hold, one quiet window
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (hold_left > 0) begin
      rsp_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!held && rsp_seen >= 150) begin
      held <= 1'b1;
      hold_left <= 400;
      rsp_stall <= 1'b1;
    end else if (rsp_seen >= 700 && rsp_seen < 1000) begin
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= ($urandom_range(99) < 38);
    end
  end

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      err_count++;
    end
  endfunction

  // compare each response with the oldest expectation
  always @(posedge clk) begin
    outcome_t e;
    if (!rst && rsp_valid && !rsp_stall) begin
      rsp_seen <= rsp_seen + 1;
      if (pending_q.size() == 0) begin
        $error("response with nothing expected");
        err_count++;
      end else begin
        e = pending_q.pop_front();
        check_field("run_status", 64'(e.status), 64'(run_status));
        check_field("next_pc", 64'(e.pc), 64'(next_pc));
        check_field("flag_zero", 64'(e.zf), 64'(flag_zero));
        check_field("flag_sign", 64'(e.sf), 64'(flag_sign));
        check_field("flag_overflow", 64'(e.of), 64'(flag_overflow));
        check_field("reg_written", 64'(e.wr), 64'(reg_written));
        check_field("reg_index", 64'(e.idx), 64'(reg_index));
        check_field("reg_value", e.val, reg_value);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule
